/* sv/ltem_pkg.sv */
package ltem_pkg;

  // Matrix kinds
  localparam logic [1:0] CMD_DIFF = 2'd0;
  localparam logic [1:0] CMD_MASS = 2'd1;
  localparam logic [1:0] CMD_ADV  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  // Datapath widths
  localparam int DIFF_W = 33;              // coordinate difference
  localparam int PROD_W = 2 * DIFF_W;      // 33x33 product
  localparam int SUM_W  = PROD_W + 1;      // sum of two products, doubled area
  localparam int DEN_W  = 66;              // |D| and constant divisors
  localparam int LO_W   = 34;              // low slice of the split multiply
  localparam int NUM_W  = 100;             // signed numerator
  localparam int DSH    = 7;               // diffusion scale 2^7
  localparam int MAG_W  = NUM_W + DSH;     // numerator magnitude
  localparam int Q_W    = 49;              // quotient bits kept
  localparam int CMP_W  = DEN_W + Q_W + 1; // compare width in the divider
  localparam int ENT_W  = 48;
  localparam int DIV_LAT = Q_W + 2;        // register levels in a divider lane

  localparam logic [DEN_W-1:0] DEN_DIAG = DEN_W'(12 << 24);
  localparam logic [DEN_W-1:0] DEN_OFF  = DEN_W'(24 << 24);
  localparam logic [DEN_W-1:0] DEN_ADV  = DEN_W'(1536);

  localparam logic [ENT_W-1:0] ENT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [ENT_W-1:0] ENT_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] node0_x;
    logic signed [31:0] node0_y;
    logic signed [31:0] node1_x;
    logic signed [31:0] node1_y;
    logic signed [31:0] node2_x;
    logic signed [31:0] node2_y;
    logic signed [31:0] coeff;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [47:0] entry_0;
    logic signed [47:0] entry_1;
    logic signed [47:0] entry_2;
    logic               degenerate;
    logic               saturated;
    logic               last_row;
  } out_t;

  // Row control that travels with the data
  typedef struct packed {
    logic       vld;
    logic [1:0] row;
    logic       degen;
  } ctl_t;

  // Issued row: edge vectors and multiplier operands
  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [31:0]       coeff;
    logic signed [DIFF_W-1:0] beta0;
    logic signed [DIFF_W-1:0] beta1;
    logic signed [DIFF_W-1:0] beta2;
    logic signed [DIFF_W-1:0] gamma0;
    logic signed [DIFF_W-1:0] gamma1;
    logic signed [DIFF_W-1:0] gamma2;
    logic signed [DIFF_W-1:0] opa1;
    logic signed [DIFF_W-1:0] opa2;
  } iss_t;

endpackage

/* sv/linear_triangle_element_matrix_unit.sv */
// P1 triangle element matrix unit. A request (start high while busy is low)
// carries one triangle and a cmd: diffusion, mass or advection; cmd 3 is taken
// and produces nothing. Each request returns three rows, one per cycle on
// consecutive cycles, each marked by a single-cycle out_valid with row 0
// first; the receiver cannot stall, so every row must be taken when shown.
// busy stays high after a request with cmd 0 to 2 until the sequencer reaches
// the last row, so such requests never overlap the three result rows; a cmd 3
// request leaves busy low. Each of the three column lanes holds a 49-stage
// restoring divider. Zero-area triangles give zero entries with degenerate
// set; clipped rows set saturated.
module linear_triangle_element_matrix_unit
  import ltem_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_result
);

  ctl_t             iss_ctl;
  iss_t             iss_data;
  ctl_t             num_ctl;
  logic [MAG_W-1:0] num_mag [3];
  logic             num_neg [3];
  logic [DEN_W-1:0] num_den [3];
  logic [ENT_W-1:0] ent [3];
  logic             esat [3];
  ctl_t             ctl_r [DIV_LAT];
  logic             out_valid_r;
  out_t             out_r, out_nxt;
  ctl_t             ctl_o;

  ltem_issue u_issue (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .iss_ctl  (iss_ctl),
    .iss_data (iss_data)
  );

  ltem_numer u_numer (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss_ctl  (iss_ctl),
    .iss_data (iss_data),
    .num_ctl  (num_ctl),
    .num_mag  (num_mag),
    .num_neg  (num_neg),
    .num_den  (num_den)
  );

  for (genvar j = 0; j < 3; j++) begin : g_lane
    ltem_div_lane u_lane (
      .clk   (clk),
      .mag   (num_mag[j]),
      .neg   (num_neg[j]),
      .den   (num_den[j]),
      .entry (ent[j]),
      .sat   (esat[j])
    );
  end

  // Carry row control alongside the divider lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        ctl_r[i].vld <= 1'b0;
      end
    end else begin
      ctl_r[0] <= num_ctl;
      for (int i = 1; i < DIV_LAT; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // Assemble the result row
  always_comb begin
    ctl_o                 = ctl_r[DIV_LAT-1];
    out_nxt.row_index     = ctl_o.row;
    out_nxt.entry_0       = ctl_o.degen ? '0 : ent[0];
    out_nxt.entry_1       = ctl_o.degen ? '0 : ent[1];
    out_nxt.entry_2       = ctl_o.degen ? '0 : ent[2];
    out_nxt.degenerate    = ctl_o.degen;
    out_nxt.saturated     = !ctl_o.degen && (esat[0] || esat[1] || esat[2]);
    out_nxt.last_row      = (ctl_o.row == ROW_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_o.vld;
    end
    out_r <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

/* sv/ltem_issue.sv */
module ltem_issue
  import ltem_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output ctl_t iss_ctl,
  output iss_t iss_data
);

  in_t        item_r;
  logic       act_r;
  logic [1:0] row_r;
  logic       accept;
  ctl_t       ctl_r;
  iss_t       iss_r;
  iss_t       iss_nxt;

  assign busy   = act_r && (row_r != ROW_LAST);
  assign accept = start && !busy;

  // Row sequencer: three rows per request with cmd 0 to 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      row_r <= ROW_FIRST;
    end else if (accept) begin
      act_r <= (in_item.cmd != CMD_NONE);
      row_r <= ROW_FIRST;
    end else if (act_r) begin
      row_r <= row_r + 2'd1;
      if (row_r == ROW_LAST) begin
        act_r <= 1'b0;
      end
    end
  end

  // Hold the request
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  // Edge vectors and row operands
  always_comb begin
    logic signed [DIFF_W-1:0] bi;
    logic signed [DIFF_W-1:0] gi;
    iss_nxt.cmd    = item_r.cmd;
    iss_nxt.coeff  = item_r.coeff;
    iss_nxt.beta0  = DIFF_W'(item_r.node1_y) - DIFF_W'(item_r.node2_y);
    iss_nxt.beta1  = DIFF_W'(item_r.node2_y) - DIFF_W'(item_r.node0_y);
    iss_nxt.beta2  = DIFF_W'(item_r.node0_y) - DIFF_W'(item_r.node1_y);
    iss_nxt.gamma0 = DIFF_W'(item_r.node2_x) - DIFF_W'(item_r.node1_x);
    iss_nxt.gamma1 = DIFF_W'(item_r.node0_x) - DIFF_W'(item_r.node2_x);
    iss_nxt.gamma2 = DIFF_W'(item_r.node1_x) - DIFF_W'(item_r.node0_x);
    case (row_r)
      2'd0: begin
        bi = iss_nxt.beta0;
        gi = iss_nxt.gamma0;
      end
      2'd1: begin
        bi = iss_nxt.beta1;
        gi = iss_nxt.gamma1;
      end
      default: begin
        bi = iss_nxt.beta2;
        gi = iss_nxt.gamma2;
      end
    endcase
    if (item_r.cmd == CMD_DIFF) begin
      iss_nxt.opa1 = bi;
      iss_nxt.opa2 = gi;
    end else begin
      iss_nxt.opa1 = DIFF_W'(item_r.vel_x);
      iss_nxt.opa2 = DIFF_W'(item_r.vel_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= act_r;
    end
    ctl_r.row   <= row_r;
    ctl_r.degen <= 1'b0;
    iss_r       <= iss_nxt;
  end

  assign iss_ctl  = ctl_r;
  assign iss_data = iss_r;

endmodule

/* sv/ltem_numer.sv */
module ltem_numer
  import ltem_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             iss_ctl,
  input  iss_t             iss_data,
  output ctl_t             num_ctl,
  output logic [MAG_W-1:0] num_mag [3],
  output logic             num_neg [3],
  output logic [DEN_W-1:0] num_den [3]
);

  logic signed [DIFF_W-1:0] bj [3];
  logic signed [DIFF_W-1:0] gj [3];

  ctl_t ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  ctl_t ctl4_nxt;

  // stage 2
  logic signed [PROD_W-1:0] pd1_r, pd2_r;
  logic signed [PROD_W-1:0] p1_r [3];
  logic signed [PROD_W-1:0] p2_r [3];
  logic [1:0]               cmd2_r, cmd3_r;
  logic signed [31:0]       c2_r, c3_r;
  // stage 3
  logic signed [SUM_W-1:0]  d3_r;
  logic signed [SUM_W-1:0]  s3_r [3];
  // stage 4
  logic signed [SUM_W-1:0]  a4_r [3];
  logic signed [31:0]       m4_r;
  logic [DEN_W-1:0]         den4_r [3], den5_r [3], den6_r [3], den7_r [3];
  logic                     sh4_r, sh5_r, sh6_r;
  logic                     ng4_r, ng5_r, ng6_r;
  logic signed [SUM_W-1:0]  a4_nxt [3];
  logic [DEN_W-1:0]         den4_nxt [3];
  logic [DEN_W-1:0]         absd;
  logic                     dneg;
  // stage 5
  logic signed [LO_W+32:0]        pl5_r [3];
  logic signed [SUM_W-LO_W+31:0]  ph5_r [3];
  // stage 6
  logic signed [NUM_W-1:0]  num6_r [3];
  // stage 7
  logic [MAG_W-1:0]         mag7_r [3];
  logic                     neg7_r [3];

  always_comb begin
    bj[0] = iss_data.beta0;
    bj[1] = iss_data.beta1;
    bj[2] = iss_data.beta2;
    gj[0] = iss_data.gamma0;
    gj[1] = iss_data.gamma1;
    gj[2] = iss_data.gamma2;
  end

  // Valid bits advance every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.vld <= 1'b0;
      ctl3_r.vld <= 1'b0;
      ctl4_r.vld <= 1'b0;
      ctl5_r.vld <= 1'b0;
      ctl6_r.vld <= 1'b0;
      ctl7_r.vld <= 1'b0;
    end else begin
      ctl2_r.vld <= iss_ctl.vld;
      ctl3_r.vld <= ctl2_r.vld;
      ctl4_r.vld <= ctl4_nxt.vld;
      ctl5_r.vld <= ctl4_r.vld;
      ctl6_r.vld <= ctl5_r.vld;
      ctl7_r.vld <= ctl6_r.vld;
    end
    ctl2_r.row   <= iss_ctl.row;
    ctl2_r.degen <= iss_ctl.degen;
    ctl3_r.row   <= ctl2_r.row;
    ctl3_r.degen <= ctl2_r.degen;
    ctl4_r.row   <= ctl4_nxt.row;
    ctl4_r.degen <= ctl4_nxt.degen;
    ctl5_r.row   <= ctl4_r.row;
    ctl5_r.degen <= ctl4_r.degen;
    ctl6_r.row   <= ctl5_r.row;
    ctl6_r.degen <= ctl5_r.degen;
    ctl7_r.row   <= ctl6_r.row;
    ctl7_r.degen <= ctl6_r.degen;
  end

  // Stage 2: area products and per column products
  always_ff @(posedge clk) begin
    pd1_r  <= iss_data.gamma2 * iss_data.beta1;
    pd2_r  <= iss_data.gamma1 * iss_data.beta2;
    cmd2_r <= iss_data.cmd;
    c2_r   <= iss_data.coeff;
    for (int j = 0; j < 3; j++) begin
      p1_r[j] <= iss_data.opa1 * bj[j];
      p2_r[j] <= iss_data.opa2 * gj[j];
    end
  end

  // Stage 3: doubled area and product sums
  always_ff @(posedge clk) begin
    d3_r   <= SUM_W'(pd1_r) - SUM_W'(pd2_r);
    cmd3_r <= cmd2_r;
    c3_r   <= c2_r;
    for (int j = 0; j < 3; j++) begin
      s3_r[j] <= SUM_W'(p1_r[j]) + SUM_W'(p2_r[j]);
    end
  end

  // Stage 4: area magnitude, operand and divisor select
  always_comb begin
    logic signed [SUM_W-1:0] dabs;
    dneg = d3_r[SUM_W-1];
    dabs = dneg ? -d3_r : d3_r;
    absd = dabs[DEN_W-1:0];
    ctl4_nxt.vld   = ctl3_r.vld;
    ctl4_nxt.row   = ctl3_r.row;
    ctl4_nxt.degen = (d3_r == '0);
    for (int j = 0; j < 3; j++) begin
      a4_nxt[j] = (cmd3_r == CMD_MASS) ? SUM_W'(absd) : s3_r[j];
      case (cmd3_r)
        CMD_DIFF: den4_nxt[j] = absd;
        CMD_MASS: den4_nxt[j] = (ctl3_r.row == 2'(j)) ? DEN_DIAG : DEN_OFF;
        default:  den4_nxt[j] = DEN_ADV;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    m4_r  <= (cmd3_r == CMD_ADV) ? 32'sd1 : c3_r;
    sh4_r <= (cmd3_r == CMD_DIFF);
    ng4_r <= (cmd3_r == CMD_ADV) && dneg;
    for (int j = 0; j < 3; j++) begin
      a4_r[j]   <= a4_nxt[j];
      den4_r[j] <= den4_nxt[j];
    end
  end

  // Stage 5: split multiply by the coefficient
  always_ff @(posedge clk) begin
    sh5_r <= sh4_r;
    ng5_r <= ng4_r;
    for (int j = 0; j < 3; j++) begin
      pl5_r[j]  <= $signed({1'b0, a4_r[j][LO_W-1:0]}) * m4_r;
      ph5_r[j]  <= $signed(a4_r[j][SUM_W-1:LO_W]) * m4_r;
      den5_r[j] <= den4_r[j];
    end
  end

  // Stage 6: merge partial products
  always_ff @(posedge clk) begin
    sh6_r <= sh5_r;
    ng6_r <= ng5_r;
    for (int j = 0; j < 3; j++) begin
      num6_r[j] <= (NUM_W'(ph5_r[j]) <<< LO_W) + NUM_W'(pl5_r[j]);
      den6_r[j] <= den5_r[j];
    end
  end

  // Stage 7: sign and magnitude, diffusion scale
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      logic [NUM_W-1:0] absn;
      absn = num6_r[j][NUM_W-1] ? NUM_W'(-num6_r[j]) : NUM_W'(num6_r[j]);
      neg7_r[j] <= num6_r[j][NUM_W-1] ^ ng6_r;
      mag7_r[j] <= sh6_r ? {absn, {DSH{1'b0}}} : MAG_W'(absn);
      den7_r[j] <= den6_r[j];
    end
  end

  assign num_ctl = ctl7_r;
  assign num_mag = mag7_r;
  assign num_neg = neg7_r;
  assign num_den = den7_r;

endmodule

/* sv/ltem_div_lane.sv */
module ltem_div_lane
  import ltem_pkg::*;
(
  input  logic             clk,
  input  logic [MAG_W-1:0] mag,
  input  logic             neg,
  input  logic [DEN_W-1:0] den,
  output logic [ENT_W-1:0] entry,
  output logic             sat
);

  localparam logic [Q_W:0] POS_LIM = (Q_W + 1)'(ENT_MAX);
  localparam logic [Q_W:0] NEG_LIM = (Q_W + 1)'(ENT_MIN);

  logic [MAG_W-1:0] rem_r [Q_W+1];
  logic [DEN_W-1:0] den_r [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic [Q_W:0]     neg_r;
  logic [Q_W:0]     big_r;
  logic [MAG_W-1:0] rem_nxt [Q_W+1];
  logic [Q_W-1:0]   q_nxt   [Q_W+1];
  logic [ENT_W-1:0] entry_r, entry_nxt;
  logic             sat_r, sat_nxt;

  // One restoring step per stage, quotient bit Q_W-s at stage s
  always_comb begin
    rem_nxt[0] = mag;
    q_nxt[0]   = '0;
    for (int s = 1; s <= Q_W; s++) begin
      logic [CMP_W-1:0] dsh;
      logic [CMP_W-1:0] remx;
      logic [CMP_W-1:0] dif;
      dsh  = CMP_W'(den_r[s-1]) << (Q_W - s);
      remx = CMP_W'(rem_r[s-1]);
      dif  = remx - dsh;
      if (remx >= dsh) begin
        rem_nxt[s] = dif[MAG_W-1:0];
        q_nxt[s]   = q_r[s-1] | (Q_W'(1) << (Q_W - s));
      end else begin
        rem_nxt[s] = rem_r[s-1];
        q_nxt[s]   = q_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    den_r[0] <= den;
    neg_r[0] <= neg;
    big_r[0] <= CMP_W'(mag) >= (CMP_W'(den) << Q_W);
    for (int s = 0; s <= Q_W; s++) begin
      rem_r[s] <= rem_nxt[s];
      q_r[s]   <= q_nxt[s];
    end
    for (int s = 1; s <= Q_W; s++) begin
      den_r[s] <= den_r[s-1];
      neg_r[s] <= neg_r[s-1];
      big_r[s] <= big_r[s-1];
    end
  end

  // Round half away from zero, then clip
  always_comb begin
    logic         rnd;
    logic [Q_W:0] qr;
    logic         ng;
    rnd = {rem_r[Q_W][DEN_W-1:0], 1'b0} >= {1'b0, den_r[Q_W]};
    qr  = {1'b0, q_r[Q_W]} + (Q_W + 1)'(rnd);
    ng  = neg_r[Q_W];
    if (big_r[Q_W] || (!ng && qr > POS_LIM) || (ng && qr > NEG_LIM)) begin
      sat_nxt   = 1'b1;
      entry_nxt = ng ? ENT_MIN : ENT_MAX;
    end else begin
      sat_nxt   = 1'b0;
      entry_nxt = ng ? -qr[ENT_W-1:0] : qr[ENT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    sat_r   <= sat_nxt;
  end

  assign entry = entry_r;
  assign sat   = sat_r;

endmodule
